@@ hdl/chunked_stop_and_wait_sender_unit_assert.svh @@
// Assertion macros for the chunked stop-and-wait sender.
`ifndef CHUNKED_STOP_AND_WAIT_SENDER_UNIT_ASSERT_SVH
`define CHUNKED_STOP_AND_WAIT_SENDER_UNIT_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define CSWSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define CSWSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/cswsu_pkg.sv @@
package cswsu_pkg;

  // Transfer geometry
  localparam int CHUNK_BYTES = 200;
  localparam int SIZE_BITS   = 24;
  localparam int LEN_BITS    = 8;
  localparam int TICK_BITS   = 16;
  localparam int ATT_BITS    = 8;
  localparam int PEND_BITS   = 8;
  localparam int CFG_W       = 16;

  // Register reset values
  localparam logic [TICK_BITS-1:0] ACK_TIMEOUT_RST = TICK_BITS'(1000);
  localparam logic [ATT_BITS-1:0]  MAX_ATTEMPTS_RST = ATT_BITS'(3);

  // Request function codes
  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_ACK    = 2'd2,
    FUNC_REJECT = 2'd3
  } func_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_ACK_TIMEOUT  = 1'b0,
    CFG_MAX_ATTEMPTS = 1'b1
  } cfg_idx_t;

  // Chunk kinds
  localparam logic KIND_ENTIRE = 1'b0;
  localparam logic KIND_BODY   = 1'b1;

endpackage

@@ hdl/chunked_stop_and_wait_sender_unit.sv @@
// Chunked stop-and-wait sender.
// Input channel (in_valid/in_ready): one request per item. func selects start
// (with in_transfer_size), tick, ack received or reject received.
// Output channel (out_valid/out_ready): exactly one result per request, telling
// whether a chunk must be sent now (offset, length, kind) and whether the
// transfer has finished and how.
// Configuration (cfg_we/cfg_index/cfg_wdata): ack timeout in ticks and the
// number of sends allowed per chunk; write only while the block is idle.
// The result of a request is valid in the cycle after it is accepted.
// Throughput: one request per cycle while results are taken; the whole
// transfer state update is one pass of logic from request to result register.
// The result register doubles as the skid stage: a new request is taken
// whenever the result register is empty or is being taken in the same cycle.
// When the receiver stalls, the result holds and in_ready drops until it goes.
// Reset (rst_n low, synchronous) returns to idle, clears all counters and
// restores the timeout to 1000 ticks and the attempt limit to 3.
`include "chunked_stop_and_wait_sender_unit_assert.svh"

module chunked_stop_and_wait_sender_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_func,
  input  logic [cswsu_pkg::SIZE_BITS-1:0] in_transfer_size,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_send_now,
  output logic [cswsu_pkg::SIZE_BITS-1:0] out_chunk_offset,
  output logic [cswsu_pkg::LEN_BITS-1:0]  out_chunk_length,
  output logic                            out_chunk_kind,
  output logic                            out_finished,
  output logic                            out_succeeded,
  input  logic                            cfg_we,
  input  logic [0:0]                      cfg_index,
  input  logic [cswsu_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int SB = cswsu_pkg::SIZE_BITS;
  localparam int LB = cswsu_pkg::LEN_BITS;
  localparam int TB = cswsu_pkg::TICK_BITS;
  localparam int AB = cswsu_pkg::ATT_BITS;
  localparam int PB = cswsu_pkg::PEND_BITS;
  localparam logic [SB-1:0] CHUNK_SZ = SB'(cswsu_pkg::CHUNK_BYTES);

  // Configuration registers
  logic [TB-1:0] timeout_r;
  logic [AB-1:0] max_att_r;

  // Transfer state
  logic          waiting_r, waiting_nxt;
  logic [SB-1:0] total_r, total_nxt;
  logic [SB-1:0] offset_r, offset_nxt;
  logic [LB-1:0] length_r, length_nxt;
  logic          first_r, first_nxt;
  logic [AB-1:0] sends_r, sends_nxt;
  logic [TB-1:0] wait_r, wait_nxt;
  logic [PB-1:0] acks_r, acks_nxt;
  logic [PB-1:0] rejs_r, rejs_nxt;

  // Result register
  logic          out_valid_r;
  logic          send_r, send_nxt;
  logic [SB-1:0] res_off_r, res_off_nxt;
  logic [LB-1:0] res_len_r, res_len_nxt;
  logic          kind_r, kind_nxt;
  logic          fin_r, fin_nxt;
  logic          ok_r, ok_nxt;

  logic in_acc;

  // Chunk arithmetic helpers
  logic [SB-1:0] start_len;
  logic [SB-1:0] ack_off;
  logic [SB-1:0] ack_rem;
  logic [SB-1:0] ack_len;
  logic [TB-1:0] wait_inc;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  assign start_len = (in_transfer_size < CHUNK_SZ) ? in_transfer_size : CHUNK_SZ;
  assign ack_off   = offset_r + SB'(length_r);
  assign ack_rem   = total_r - ack_off;
  assign ack_len   = (ack_rem < CHUNK_SZ) ? ack_rem : CHUNK_SZ;
  assign wait_inc  = (wait_r != '1) ? wait_r + TB'(1) : wait_r;

  // Compute next transfer state and the result for the current request
  always_comb begin
    waiting_nxt = waiting_r;
    total_nxt   = total_r;
    offset_nxt  = offset_r;
    length_nxt  = length_r;
    first_nxt   = first_r;
    sends_nxt   = sends_r;
    wait_nxt    = wait_r;
    acks_nxt    = acks_r;
    rejs_nxt    = rejs_r;
    send_nxt    = 1'b0;
    res_off_nxt = '0;
    res_len_nxt = '0;
    kind_nxt    = 1'b0;
    fin_nxt     = 1'b0;
    ok_nxt      = 1'b0;
    case (cswsu_pkg::func_t'(in_func))
      cswsu_pkg::FUNC_START: begin
        total_nxt  = in_transfer_size;
        offset_nxt = '0;
        first_nxt  = 1'b1;
        wait_nxt   = '0;
        if (in_transfer_size == '0) begin
          length_nxt  = '0;
          sends_nxt   = '0;
          waiting_nxt = 1'b0;
          fin_nxt     = 1'b1;
          ok_nxt      = 1'b1;
        end else begin
          length_nxt  = start_len[LB-1:0];
          sends_nxt   = AB'(1);
          waiting_nxt = 1'b1;
          send_nxt    = 1'b1;
          res_len_nxt = start_len[LB-1:0];
          kind_nxt    = cswsu_pkg::KIND_ENTIRE;
        end
      end
      cswsu_pkg::FUNC_ACK: begin
        if (acks_r != '1) acks_nxt = acks_r + PB'(1);
      end
      cswsu_pkg::FUNC_REJECT: begin
        if (rejs_r != '1) rejs_nxt = rejs_r + PB'(1);
      end
      cswsu_pkg::FUNC_TICK: begin
        if (waiting_r) begin
          if (acks_r != '0) begin
            // Take the ack: advance to the next chunk or finish
            acks_nxt   = acks_r - PB'(1);
            offset_nxt = ack_off;
            first_nxt  = 1'b0;
            if (ack_off >= total_r) begin
              waiting_nxt = 1'b0;
              fin_nxt     = 1'b1;
              ok_nxt      = 1'b1;
            end else begin
              length_nxt  = ack_len[LB-1:0];
              sends_nxt   = AB'(1);
              wait_nxt    = '0;
              send_nxt    = 1'b1;
              res_off_nxt = ack_off;
              res_len_nxt = ack_len[LB-1:0];
              kind_nxt    = cswsu_pkg::KIND_BODY;
            end
          end else if (rejs_r != '0) begin
            // Abort on reject
            rejs_nxt    = rejs_r - PB'(1);
            waiting_nxt = 1'b0;
            fin_nxt     = 1'b1;
          end else begin
            // Count the wait; resend or give up at the timeout
            wait_nxt = wait_inc;
            if (wait_inc >= timeout_r) begin
              if (sends_r >= max_att_r) begin
                waiting_nxt = 1'b0;
                fin_nxt     = 1'b1;
              end else begin
                sends_nxt   = sends_r + AB'(1);
                wait_nxt    = '0;
                send_nxt    = 1'b1;
                res_off_nxt = offset_r;
                res_len_nxt = length_r;
                kind_nxt    = first_r ? cswsu_pkg::KIND_ENTIRE : cswsu_pkg::KIND_BODY;
              end
            end
          end
        end
      end
      default: begin
        waiting_nxt = waiting_r;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= cswsu_pkg::ACK_TIMEOUT_RST;
      max_att_r <= cswsu_pkg::MAX_ATTEMPTS_RST;
    end else if (cfg_we) begin
      case (cswsu_pkg::cfg_idx_t'(cfg_index))
        cswsu_pkg::CFG_ACK_TIMEOUT:  timeout_r <= cfg_wdata[TB-1:0];
        cswsu_pkg::CFG_MAX_ATTEMPTS: max_att_r <= cfg_wdata[AB-1:0];
        default: ;
      endcase
    end
  end

  // Advance transfer state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r <= 1'b0;
      total_r   <= '0;
      offset_r  <= '0;
      length_r  <= '0;
      first_r   <= 1'b0;
      sends_r   <= '0;
      wait_r    <= '0;
      acks_r    <= '0;
      rejs_r    <= '0;
    end else if (in_acc) begin
      waiting_r <= waiting_nxt;
      total_r   <= total_nxt;
      offset_r  <= offset_nxt;
      length_r  <= length_nxt;
      first_r   <= first_nxt;
      sends_r   <= sends_nxt;
      wait_r    <= wait_nxt;
      acks_r    <= acks_nxt;
      rejs_r    <= rejs_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      send_r    <= send_nxt;
      res_off_r <= res_off_nxt;
      res_len_r <= res_len_nxt;
      kind_r    <= kind_nxt;
      fin_r     <= fin_nxt;
      ok_r      <= ok_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_send_now     = send_r;
  assign out_chunk_offset = res_off_r;
  assign out_chunk_length = res_len_r;
  assign out_chunk_kind   = kind_r;
  assign out_finished     = fin_r;
  assign out_succeeded    = ok_r;

  // Checks
  `CSWSU_ASSERT_NOW(a_send_xor_end, out_valid_r, !(send_r && fin_r), "send and finish together")
  `CSWSU_ASSERT_NOW(a_wait_len, waiting_r, (length_r != '0) && (offset_r < total_r), "bad chunk while waiting")
  `CSWSU_ASSERT_NEXT(a_zero_start, in_acc && (in_func == cswsu_pkg::FUNC_START) && (in_transfer_size == '0), out_valid_r && fin_r && ok_r && !send_r, "zero-size start did not succeed")

endmodule
